// ===== sv/serial_frame_receiver_sum_check_unit_defines.svh =====
// Assertion macros shared by the frame receiver modules.
`ifndef SERIAL_FRAME_RECEIVER_SUM_CHECK_UNIT_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_SUM_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define SFRSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define SFRSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sfrsc_pkg.sv =====
// Types and constants for the serial frame receiver with sum check.
package sfrsc_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned PAYLOAD_W    = 64;
  localparam int unsigned CFG_INDEX_W  = 8;
  localparam int unsigned IDX_W        = 4;
  localparam logic [IDX_W-1:0] PAYLOAD_BYTES = IDX_W'(PAYLOAD_W / BYTE_W);

  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH = CFG_INDEX_W'(1);

  localparam logic [BYTE_W-1:0] HEADER_RESET = BYTE_W'(85);
  localparam logic [BYTE_W-1:0] LENGTH_RESET = BYTE_W'(14);

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_LENGTH = 6'b000010,
    PH_ID_HI  = 6'b000100,
    PH_ID_LO  = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_CHECK  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [ID_W-1:0]      msg_id;
    logic [PAYLOAD_W-1:0] payload;
    logic [BYTE_W-1:0]    count_byte;
  } frame_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_value;
    logic [BYTE_W-1:0] length_value;
  } cfg_t;

endpackage

// ===== sv/sfrsc_parser.sv =====
// Byte-at-a-time frame parser: phase tracking, field capture and running sum.
`include "serial_frame_receiver_sum_check_unit_defines.svh"

module sfrsc_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [sfrsc_pkg::BYTE_W-1:0] rx_byte,
  input  sfrsc_pkg::cfg_t             cfg,
  output logic                        push,
  output sfrsc_pkg::frame_t           frame
);

  sfrsc_pkg::phase_t                 phase, phase_next;
  logic [sfrsc_pkg::IDX_W-1:0]       payload_index, payload_index_next;
  logic [sfrsc_pkg::BYTE_W-1:0]      running_sum, running_sum_next;
  logic [sfrsc_pkg::ID_W-1:0]        held_id, held_id_next;
  logic [sfrsc_pkg::PAYLOAD_W-1:0]   held_payload, held_payload_next;
  logic [sfrsc_pkg::BYTE_W-1:0]      held_count, held_count_next;

  always_comb begin
    phase_next         = phase;
    payload_index_next = payload_index;
    running_sum_next   = running_sum;
    held_id_next       = held_id;
    held_payload_next  = held_payload;
    held_count_next    = held_count;
    push               = 1'b0;
    if (accept) begin
      case (phase)
        sfrsc_pkg::PH_LENGTH: begin
          phase_next = (rx_byte == cfg.length_value) ? sfrsc_pkg::PH_ID_HI
                                                     : sfrsc_pkg::PH_HEADER;
        end
        sfrsc_pkg::PH_ID_HI: begin
          held_id_next = {rx_byte, sfrsc_pkg::BYTE_W'(0)};
          phase_next   = sfrsc_pkg::PH_ID_LO;
        end
        sfrsc_pkg::PH_ID_LO: begin
          held_id_next       = {held_id[sfrsc_pkg::ID_W-1:sfrsc_pkg::BYTE_W], rx_byte};
          payload_index_next = '0;
          phase_next         = sfrsc_pkg::PH_DATA;
        end
        sfrsc_pkg::PH_DATA: begin
          if (payload_index < sfrsc_pkg::PAYLOAD_BYTES) begin
            held_payload_next  = {held_payload[sfrsc_pkg::PAYLOAD_W-sfrsc_pkg::BYTE_W-1:0],
                                  rx_byte};
            running_sum_next   = running_sum + rx_byte;
            payload_index_next = payload_index + 1'b1;
          end else begin
            held_count_next    = rx_byte;
            payload_index_next = '0;
            phase_next         = sfrsc_pkg::PH_CHECK;
          end
        end
        sfrsc_pkg::PH_CHECK: begin
          push              = (rx_byte == running_sum);
          running_sum_next  = '0;
          held_payload_next = '0;
          phase_next        = sfrsc_pkg::PH_HEADER;
        end
        default: begin
          // header hunt; also recovers from any stray phase code
          phase_next = (rx_byte == cfg.header_value) ? sfrsc_pkg::PH_LENGTH
                                                     : sfrsc_pkg::PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sfrsc_pkg::PH_HEADER;
      payload_index <= '0;
      running_sum   <= '0;
    end else begin
      phase         <= phase_next;
      payload_index <= payload_index_next;
      running_sum   <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    held_id      <= held_id_next;
    held_payload <= held_payload_next;
    held_count   <= held_count_next;
  end

  assign frame.msg_id     = held_id;
  assign frame.payload    = held_payload;
  assign frame.count_byte = held_count;

  `SFRSC_ASSERT_IMPL(a_index_idle, phase != sfrsc_pkg::PH_DATA, payload_index == '0, "index off")
  `SFRSC_ASSERT_IMPL(a_push_in_check, push, phase == sfrsc_pkg::PH_CHECK && accept, "stray push")

endmodule

// ===== sv/sfrsc_out_buf.sv =====
// Two-entry output stage (result register plus skid) between parser and downstream.
`include "serial_frame_receiver_sum_check_unit_defines.svh"

module sfrsc_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sfrsc_pkg::frame_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output sfrsc_pkg::frame_t out_data
);

  logic              main_valid;
  logic              skid_valid;
  sfrsc_pkg::frame_t main_data;
  sfrsc_pkg::frame_t skid_data;
  logic              main_free;

  // skid slot is empty whenever upstream may send, so a push always has room
  assign space     = !skid_valid;
  assign main_free = out_ready || !main_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign out_valid = main_valid;
  assign out_data  = main_data;

  `SFRSC_ASSERT_IMPL(a_skid_behind_main, skid_valid, main_valid, "skid without main entry")
  `SFRSC_ASSERT_IMPL(a_push_has_room, push, !skid_valid, "push into full output stage")
  `SFRSC_ASSERT_NEXT(a_skid_drains, skid_valid && out_ready, main_valid && !skid_valid, "stuck")

endmodule

// ===== sv/serial_frame_receiver_sum_check_unit.sv =====
// Top level: config registers, frame parser and output stage.
// Throughput: one rx byte per cycle, sustained while the two-entry output stage has room;
// input ready drops only while the output skid entry is occupied.
// Results: a frame whose checksum byte matches the running sum is registered into the output stage.
// Reset (rst, synchronous) clears parser phase, index, sum and output stage and loads
// header_value = 85, length_value = 14; the config port is always ready.
module serial_frame_receiver_sum_check_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sfrsc_pkg::BYTE_W-1:0]        rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sfrsc_pkg::ID_W-1:0]          msg_id,
  output logic [sfrsc_pkg::PAYLOAD_W-1:0]     payload,
  output logic [sfrsc_pkg::BYTE_W-1:0]        count_byte,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfrsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sfrsc_pkg::BYTE_W-1:0]        cfg_data
);

  sfrsc_pkg::cfg_t   cfg;
  sfrsc_pkg::frame_t frame;
  sfrsc_pkg::frame_t out_data;
  logic              accept;
  logic              push;
  logic              space;

  assign cfg_ready = 1'b1;

  // writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_value <= sfrsc_pkg::HEADER_RESET;
      cfg.length_value <= sfrsc_pkg::LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfrsc_pkg::CFG_HEADER: cfg.header_value <= cfg_data;
        sfrsc_pkg::CFG_LENGTH: cfg.length_value <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  sfrsc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .push    (push),
    .frame   (frame)
  );

  sfrsc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (frame),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign msg_id     = out_data.msg_id;
  assign payload    = out_data.payload;
  assign count_byte = out_data.count_byte;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the serial frame receiver with additive checksum.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_PCT    = 30;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [sfrsc_pkg::BYTE_W-1:0]      rx_byte = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [sfrsc_pkg::ID_W-1:0]        msg_id;
  logic [sfrsc_pkg::PAYLOAD_W-1:0]   payload;
  logic [sfrsc_pkg::BYTE_W-1:0]      count_byte;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [sfrsc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sfrsc_pkg::BYTE_W-1:0]      cfg_data = '0;

  serial_frame_receiver_sum_check_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .msg_id     (msg_id),
    .payload    (payload),
    .count_byte (count_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Parser mirror and its copy of the registers
  sfrsc_pkg::phase_t               parse_ph = sfrsc_pkg::PH_HEADER;
  logic [sfrsc_pkg::IDX_W-1:0]     idx_acc = '0;
  logic [sfrsc_pkg::BYTE_W-1:0]    sum_acc = '0;
  logic [sfrsc_pkg::ID_W-1:0]      id_acc = '0;
  logic [sfrsc_pkg::PAYLOAD_W-1:0] payload_acc = '0;
  logic [sfrsc_pkg::BYTE_W-1:0]    count_acc = '0;
  logic [sfrsc_pkg::BYTE_W-1:0]    header_reg = sfrsc_pkg::HEADER_RESET;
  logic [sfrsc_pkg::BYTE_W-1:0]    length_reg = sfrsc_pkg::LENGTH_RESET;

  logic [sfrsc_pkg::BYTE_W-1:0] pending_bytes[$];
  sfrsc_pkg::frame_t            expected_frames[$];

  bit          hold_input = 1'b0;
  bit          no_idle = 1'b0;
  bit          rx_byte_taken = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  task automatic advance_parser(input logic [sfrsc_pkg::BYTE_W-1:0] b);
    case (parse_ph)
      sfrsc_pkg::PH_LENGTH: begin
        parse_ph = (b == length_reg) ? sfrsc_pkg::PH_ID_HI : sfrsc_pkg::PH_HEADER;
      end
      sfrsc_pkg::PH_ID_HI: begin
        id_acc   = {b, 8'h00};
        parse_ph = sfrsc_pkg::PH_ID_LO;
      end
      sfrsc_pkg::PH_ID_LO: begin
        id_acc   = id_acc | sfrsc_pkg::ID_W'(b);
        idx_acc  = '0;
        parse_ph = sfrsc_pkg::PH_DATA;
      end
      sfrsc_pkg::PH_DATA: begin
        if (idx_acc < sfrsc_pkg::PAYLOAD_BYTES) begin
          payload_acc = {payload_acc[sfrsc_pkg::PAYLOAD_W-sfrsc_pkg::BYTE_W-1:0], b};
          sum_acc     = sum_acc + b;
          idx_acc     = idx_acc + 1'b1;
        end else begin
          count_acc = b;
          idx_acc   = '0;
          parse_ph  = sfrsc_pkg::PH_CHECK;
        end
      end
      sfrsc_pkg::PH_CHECK: begin
        if (b == sum_acc) expected_frames.push_back({id_acc, payload_acc, count_acc});
        sum_acc     = '0;
        payload_acc = '0;
        parse_ph    = sfrsc_pkg::PH_HEADER;
      end
      default: begin
        parse_ph = (b == header_reg) ? sfrsc_pkg::PH_LENGTH : sfrsc_pkg::PH_HEADER;
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what,
                               input logic [sfrsc_pkg::PAYLOAD_W-1:0] want,
                               input logic [sfrsc_pkg::PAYLOAD_W-1:0] got);
    if (mismatch_count < 10)
      $display("mismatch: %s expected %h got %h", what, want, got);
    mismatch_count++;
  endtask

  // Input driver: change on the falling edge, hold until the transaction completes
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || rx_byte_taken) begin
      rx_byte_taken = 1'b0;
      if (pending_bytes.size() != 0 && !hold_input &&
          (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        rx_byte  <= pending_bytes[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      advance_parser(rx_byte);
      void'(pending_bytes.pop_front());
      rx_byte_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Result monitor
  always @(posedge clk) begin : check_frames
    sfrsc_pkg::frame_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        flag_mismatch("unexpected msg_id", '0, sfrsc_pkg::PAYLOAD_W'(msg_id));
      end else begin
        want = expected_frames.pop_front();
        if (msg_id != want.msg_id)
          flag_mismatch("msg_id", sfrsc_pkg::PAYLOAD_W'(want.msg_id),
                        sfrsc_pkg::PAYLOAD_W'(msg_id));
        if (payload != want.payload)
          flag_mismatch("payload", want.payload, payload);
        if (count_byte != want.count_byte)
          flag_mismatch("count_byte", sfrsc_pkg::PAYLOAD_W'(want.count_byte),
                        sfrsc_pkg::PAYLOAD_W'(count_byte));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("serial_frame_receiver_sum_check_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [sfrsc_pkg::BYTE_W-1:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return sfrsc_pkg::BYTE_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [sfrsc_pkg::PAYLOAD_W-1:0] payload_word();
    return {rand_byte(), rand_byte(), rand_byte(), rand_byte(),
            rand_byte(), rand_byte(), rand_byte(), rand_byte()};
  endfunction

  task automatic queue_frame(input bit with_header, input logic [sfrsc_pkg::ID_W-1:0] id,
                             input logic [sfrsc_pkg::PAYLOAD_W-1:0] data,
                             input logic [sfrsc_pkg::BYTE_W-1:0] cnt,
                             input logic [sfrsc_pkg::BYTE_W-1:0] sum_err);
    logic [sfrsc_pkg::BYTE_W-1:0] sum;
    sum = '0;
    if (with_header) pending_bytes.push_back(header_reg);
    pending_bytes.push_back(length_reg);
    pending_bytes.push_back(id[15:8]);
    pending_bytes.push_back(id[7:0]);
    for (int k = 7; k >= 0; k--) begin
      pending_bytes.push_back(data[k*8 +: 8]);
      sum = sum + data[k*8 +: 8];
    end
    pending_bytes.push_back(cnt);
    pending_bytes.push_back(sum + sum_err);
  endtask

  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned goal;
    int unsigned pick;
    int unsigned cut;
    logic [sfrsc_pkg::BYTE_W-1:0] noise;
    goal = pending_bytes.size() + n_bytes;
    while (pending_bytes.size() < goal) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        queue_frame(1'b1, {rand_byte(), rand_byte()}, payload_word(), rand_byte(), 8'h00);
      end else if (pick < 75) begin
        queue_frame(1'b1, {rand_byte(), rand_byte()}, payload_word(), rand_byte(),
                    sfrsc_pkg::BYTE_W'($urandom_range(255, 1)));
      end else if (pick < 85) begin
        pending_bytes.push_back(header_reg);
        pending_bytes.push_back(length_reg ^ sfrsc_pkg::BYTE_W'($urandom_range(255, 1)));
      end else if (pick < 95) begin
        noise = sfrsc_pkg::BYTE_W'($urandom_range(255));
        // mostly keep stray bytes from opening a frame
        if (noise == header_reg && $urandom_range(3) != 0) noise = noise ^ 8'h80;
        pending_bytes.push_back(noise);
      end else begin
        // frame cut short; following bytes get absorbed into it
        cut = $urandom_range(7);
        pending_bytes.push_back(header_reg);
        pending_bytes.push_back(length_reg);
        pending_bytes.push_back(rand_byte());
        pending_bytes.push_back(rand_byte());
        repeat (cut) pending_bytes.push_back(rand_byte());
      end
    end
  endtask

  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sfrsc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [sfrsc_pkg::BYTE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == sfrsc_pkg::CFG_HEADER) header_reg = val;
    else if (idx == sfrsc_pkg::CFG_LENGTH) length_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: stray byte, wrong length, all-ones frame, register write mid-frame
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(header_reg);
    pending_bytes.push_back(length_reg ^ 8'h01);
    queue_frame(1'b1, 16'hFFFF, '1, 8'h00, 8'h00);
    pending_bytes.push_back(header_reg);
    settle();
    write_reg(sfrsc_pkg::CFG_LENGTH, 8'h00);
    queue_frame(1'b0, 16'h0000, '0, 8'hFF, 8'h00);

    random_traffic(250);
    settle();
    write_reg(sfrsc_pkg::CFG_HEADER, 8'h00);
    write_reg(sfrsc_pkg::CFG_INDEX_W'(2), 8'h5A);

    // sender holds back mid-phase until all results are out
    random_traffic(250);
    while (pending_bytes.size() >= 125) @(posedge clk);
    hold_input = 1'b1;
    while (in_valid || expected_frames.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    hold_input = 1'b0;
    settle();
    write_reg(sfrsc_pkg::CFG_HEADER, 8'hFF);
    write_reg(sfrsc_pkg::CFG_LENGTH, 8'hFF);
    write_reg(sfrsc_pkg::CFG_INDEX_W'(255), 8'hA5);

    no_idle = 1'b1;
    random_traffic(250);
    settle();
    no_idle = 1'b0;
    write_reg(sfrsc_pkg::CFG_HEADER, 8'hAA);
    write_reg(sfrsc_pkg::CFG_LENGTH, 8'hAA);

    random_traffic(250);
    settle();
    write_reg(sfrsc_pkg::CFG_HEADER, sfrsc_pkg::BYTE_W'($urandom_range(255)));
    write_reg(sfrsc_pkg::CFG_LENGTH, sfrsc_pkg::BYTE_W'($urandom_range(255)));
    write_reg(sfrsc_pkg::CFG_INDEX_W'($urandom_range(255, 2)),
              sfrsc_pkg::BYTE_W'($urandom_range(255)));

    random_traffic(250);
    settle();
    write_reg(sfrsc_pkg::CFG_HEADER, sfrsc_pkg::HEADER_RESET);
    write_reg(sfrsc_pkg::CFG_LENGTH, sfrsc_pkg::LENGTH_RESET);

    random_traffic(300);
    settle();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("serial_frame_receiver_sum_check_unit regression: pass");
    end else begin
      $display("serial_frame_receiver_sum_check_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sfrsc_pkg.sv
sv/sfrsc_parser.sv
sv/sfrsc_out_buf.sv
sv/serial_frame_receiver_sum_check_unit.sv
sim/tb_top.sv
